// File: rtl/eerm_pkg.sv
// ----------------------------------------------------------------------------
// eerm_pkg
// Shared widths, constants and controller/datapath interface types for the
// moving average event rate meter.
// ----------------------------------------------------------------------------
package eerm_pkg;

    localparam int FRAC_BITS  = 16;             // fraction bits of the rates
    localparam int ACC_BITS   = 40;             // interval accumulator width
    localparam int RECIP_FRAC = 16;             // fraction bits of the reciprocal
    localparam int RATE_BITS  = 32 + FRAC_BITS;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_W      = 48;
    localparam int M_DATA_W   = 3 * OUT_W;

    // The shared multiplier takes a 16-bit factor and one slice of a wide value.
    localparam int SPLIT   = 16;
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = ((ACC_BITS > RATE_BITS) ? ACC_BITS : RATE_BITS) - SPLIT;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int STEP_W  = PROD_W + 1;
    localparam int WIDE_W  = 64;

    localparam int SHR = (FRAC_BITS >= RECIP_FRAC) ? 0 : RECIP_FRAC - FRAC_BITS;
    localparam int SHL = (FRAC_BITS <= RECIP_FRAC) ? 0 : FRAC_BITS - RECIP_FRAC;

    localparam logic [WIDE_W-1:0] RATE_MAX_W = (64'd1 << RATE_BITS) - 64'd1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_ONE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_FIVE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_FIFTEEN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RECIPROCAL    = 2'd3;

    localparam logic [CFG_W-1:0] ALPHA_ONE_RST     = 16'd5240;
    localparam logic [CFG_W-1:0] ALPHA_FIVE_RST    = 16'd1083;
    localparam logic [CFG_W-1:0] ALPHA_FIFTEEN_RST = 16'd363;
    localparam logic [CFG_W-1:0] RECIPROCAL_RST    = 16'd13107;

    typedef logic [1:0] lane_t;
    localparam lane_t LANE_ONE     = 2'd0;
    localparam lane_t LANE_FIVE    = 2'd1;
    localparam lane_t LANE_FIFTEEN = 2'd2;

    typedef enum logic [1:0] {
        MUL_ACC_LO  = 2'd0,
        MUL_ACC_HI  = 2'd1,
        MUL_DIFF_LO = 2'd2,
        MUL_DIFF_HI = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    acc_load;    // add the accepted count into the accumulator
        logic    mul_en;      // register a product of the shared multiplier
        mul_op_t mul_op;
        logic    lo_capture;  // keep the low partial product
        logic    inst_load;   // form the instant rate, clear the accumulator
        logic    rates_seed;  // first tick: load all rates with the instant rate
        logic    diff_load;
        logic    step_load;
        logic    rate_update;
        lane_t   lane;
        logic    out_load;
    } eerm_cmd_t;

    typedef struct packed {
        logic tick_in;
        logic rates_init;
        logic out_free;
    } eerm_status_t;

endpackage

// File: rtl/ewma_event_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// ewma_event_rate_meter_unit
// Event counter with one, five and fifteen minute moving average rates.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_*      in         tdata: event_count[15:0]; tuser: interval_tick
//   m_*      out        tdata: rate_one_minute_out[47:0],
//                              rate_five_minute_out[47:0],
//                              rate_fifteen_minute_out[47:0]
//   cfg_*    in         cfg_addr selects alpha 1/5/15 minute or reciprocal
//
// An item without a tick goes straight from acceptance to the hand-off;
// a tick first forms the instant rate, then the first one after reset
// seeds all rates and each later one updates the three lanes. The single
// shared 16x32 multiplier serves the instant rate twice and each lane twice.
// Reset is synchronous and restores the register defaults and zero rates.
// A result waiting in the output register does not block acceptance; the
// block only holds its final step while that register is still occupied.
// ----------------------------------------------------------------------------
module ewma_event_rate_meter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [eerm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [eerm_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [eerm_pkg::COUNT_W-1:0]        s_tdata,  // event_count
    input  logic                                s_tuser,  // interval_tick
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rate_one_minute_out, rate_five_minute_out, rate_fifteen_minute_out
    output logic [eerm_pkg::M_DATA_W-1:0]       m_tdata
);

    eerm_pkg::eerm_cmd_t    cmd;
    eerm_pkg::eerm_status_t status;

    eerm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    eerm_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/eerm_ctrl.sv
// ----------------------------------------------------------------------------
// eerm_ctrl
// Sequencer for the rate meter: accepts an item; for a tick walks the shared
// multiplier through the instant rate and, once seeded, the lanes; hands off.
// ----------------------------------------------------------------------------
module eerm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  eerm_pkg::eerm_status_t status,
    output eerm_pkg::eerm_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_INST_LO  = 10'b0000000010,
        S_INST_HI  = 10'b0000000100,
        S_INST_SUM = 10'b0000001000,
        S_DIFF     = 10'b0000010000,
        S_MUL_LO   = 10'b0000100000,
        S_MUL_HI   = 10'b0001000000,
        S_STEP     = 10'b0010000000,
        S_UPDATE   = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    eerm_pkg::lane_t    lane_reg, lane_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lane_reg  <= eerm_pkg::LANE_ONE;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.mul_op = eerm_pkg::MUL_ACC_LO;
        cmd.lane   = lane_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.acc_load = 1'b1;
                    state_next   = status.tick_in ? S_INST_LO : S_DONE;
                end
            end
            S_INST_LO: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = eerm_pkg::MUL_ACC_LO;
                state_next = S_INST_HI;
            end
            S_INST_HI: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_op     = eerm_pkg::MUL_ACC_HI;
                cmd.lo_capture = 1'b1;
                state_next     = S_INST_SUM;
            end
            S_INST_SUM: begin
                cmd.inst_load = 1'b1;
                lane_next     = eerm_pkg::LANE_ONE;
                if (status.rates_init) begin
                    state_next = S_DIFF;
                end else begin
                    cmd.rates_seed = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = S_MUL_LO;
            end
            S_MUL_LO: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = eerm_pkg::MUL_DIFF_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_op     = eerm_pkg::MUL_DIFF_HI;
                cmd.lo_capture = 1'b1;
                state_next     = S_STEP;
            end
            S_STEP: begin
                cmd.step_load = 1'b1;
                state_next    = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.rate_update = 1'b1;
                if (lane_reg == eerm_pkg::LANE_FIFTEEN) begin
                    state_next = S_DONE;
                end else begin
                    lane_next  = lane_reg + eerm_pkg::lane_t'(1);
                    state_next = S_DIFF;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/eerm_dpath.sv
// ----------------------------------------------------------------------------
// eerm_dpath
// Datapath of the rate meter: configuration registers, interval accumulator,
// one shared 16-bit by slice multiplier, three rate registers and the output
// register.
// ----------------------------------------------------------------------------
module eerm_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [eerm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [eerm_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [eerm_pkg::COUNT_W-1:0]         s_tdata,
    input  logic                                 s_tuser,
    input  eerm_pkg::eerm_cmd_t                  cmd,
    output eerm_pkg::eerm_status_t               status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [eerm_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int AB = eerm_pkg::ACC_BITS;
    localparam int RB = eerm_pkg::RATE_BITS;
    localparam int PW = eerm_pkg::PROD_W;
    localparam int SW = eerm_pkg::STEP_W;
    localparam int WW = eerm_pkg::WIDE_W;
    localparam int OW = eerm_pkg::OUT_W;

    logic [eerm_pkg::CFG_W-1:0] alpha_one_reg, alpha_five_reg, alpha_fifteen_reg;
    logic [eerm_pkg::CFG_W-1:0] recip_reg;

    logic [AB-1:0] acc_reg;
    logic          init_reg;
    logic [RB-1:0] rate_one_reg, rate_five_reg, rate_fifteen_reg;
    logic          m_valid_reg;

    logic [RB-1:0]               inst_reg;
    logic [RB-1:0]               diff_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic [PW-1:0]               lo_reg;
    logic [SW-1:0]               step_reg;
    logic [eerm_pkg::M_DATA_W-1:0] m_data_reg;

    logic [AB:0]                 acc_sum;
    logic [AB-1:0]               acc_sat;
    logic [eerm_pkg::MUL_A_W-1:0] alpha_sel, mul_a;
    logic [eerm_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]               mul_p;
    logic [RB-1:0]               rate_sel;
    logic [WW-1:0]               inst_full, inst_conv;
    logic [RB-1:0]               inst_next;
    logic [RB:0]                 diff_raw, diff_neg;
    logic [SW-1:0]               step_next;
    logic [WW-1:0]               up_sum;
    logic [RB-1:0]               rate_new;
    logic [WW-1:0]               out_one_w, out_five_w, out_fifteen_w;

    // Accumulator add saturates at all ones.
    assign acc_sum = {1'b0, acc_reg} + (AB + 1)'(s_tdata);
    assign acc_sat = acc_sum[AB] ? {AB{1'b1}} : acc_sum[AB-1:0];

    always_comb begin
        case (cmd.lane)
            eerm_pkg::LANE_ONE: begin
                alpha_sel = alpha_one_reg;
                rate_sel  = rate_one_reg;
            end
            eerm_pkg::LANE_FIVE: begin
                alpha_sel = alpha_five_reg;
                rate_sel  = rate_five_reg;
            end
            default: begin
                alpha_sel = alpha_fifteen_reg;
                rate_sel  = rate_fifteen_reg;
            end
        endcase
    end

    always_comb begin
        case (cmd.mul_op)
            eerm_pkg::MUL_ACC_LO: begin
                mul_a = recip_reg;
                mul_b = eerm_pkg::MUL_B_W'(acc_reg[eerm_pkg::SPLIT-1:0]);
            end
            eerm_pkg::MUL_ACC_HI: begin
                mul_a = recip_reg;
                mul_b = eerm_pkg::MUL_B_W'(acc_reg[AB-1:eerm_pkg::SPLIT]);
            end
            eerm_pkg::MUL_DIFF_LO: begin
                mul_a = alpha_sel;
                mul_b = eerm_pkg::MUL_B_W'(diff_reg[eerm_pkg::SPLIT-1:0]);
            end
            default: begin
                mul_a = alpha_sel;
                mul_b = eerm_pkg::MUL_B_W'(diff_reg[RB-1:eerm_pkg::SPLIT]);
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Instant rate: high partial product sits in prod_reg, low one in lo_reg.
    assign inst_full = (WW'(prod_reg) << eerm_pkg::SPLIT) + WW'(lo_reg);

    always_comb begin
        if (eerm_pkg::SHL > 0) begin
            if (inst_full > (eerm_pkg::RATE_MAX_W >> eerm_pkg::SHL)) begin
                inst_conv = eerm_pkg::RATE_MAX_W;
            end else begin
                inst_conv = inst_full << eerm_pkg::SHL;
            end
        end else begin
            inst_conv = inst_full >> eerm_pkg::SHR;
        end
        if (inst_conv > eerm_pkg::RATE_MAX_W) begin
            inst_next = {RB{1'b1}};
        end else begin
            inst_next = inst_conv[RB-1:0];
        end
    end

    assign diff_raw = {1'b0, inst_reg} - {1'b0, rate_sel};
    assign diff_neg = (RB + 1)'(0) - diff_raw;

    // A negative step is rounded away from zero so the update floors exactly.
    assign step_next = SW'(prod_reg) + SW'(lo_reg >> eerm_pkg::SPLIT)
                     + SW'(neg_reg && (lo_reg[eerm_pkg::SPLIT-1:0] != '0));

    assign up_sum = WW'(rate_sel) + WW'(step_reg);

    always_comb begin
        if (neg_reg) begin
            if (WW'(step_reg) > WW'(rate_sel)) begin
                rate_new = '0;
            end else begin
                rate_new = rate_sel - RB'(step_reg);
            end
        end else begin
            if (up_sum > eerm_pkg::RATE_MAX_W) begin
                rate_new = {RB{1'b1}};
            end else begin
                rate_new = up_sum[RB-1:0];
            end
        end
    end

    assign out_one_w     = WW'(rate_one_reg);
    assign out_five_w    = WW'(rate_five_reg);
    assign out_fifteen_w = WW'(rate_fifteen_reg);

    // Configuration and block state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_one_reg     <= eerm_pkg::ALPHA_ONE_RST;
            alpha_five_reg    <= eerm_pkg::ALPHA_FIVE_RST;
            alpha_fifteen_reg <= eerm_pkg::ALPHA_FIFTEEN_RST;
            recip_reg         <= eerm_pkg::RECIPROCAL_RST;
            acc_reg           <= '0;
            init_reg          <= 1'b0;
            rate_one_reg      <= '0;
            rate_five_reg     <= '0;
            rate_fifteen_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    eerm_pkg::REG_ALPHA_ONE:     alpha_one_reg     <= cfg_wdata;
                    eerm_pkg::REG_ALPHA_FIVE:    alpha_five_reg    <= cfg_wdata;
                    eerm_pkg::REG_ALPHA_FIFTEEN: alpha_fifteen_reg <= cfg_wdata;
                    eerm_pkg::REG_RECIPROCAL:    recip_reg         <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.acc_load) begin
                acc_reg <= acc_sat;
            end else if (cmd.inst_load) begin
                acc_reg <= '0;
            end
            if (cmd.rates_seed) begin
                init_reg         <= 1'b1;
                rate_one_reg     <= inst_next;
                rate_five_reg    <= inst_next;
                rate_fifteen_reg <= inst_next;
            end else if (cmd.rate_update) begin
                case (cmd.lane)
                    eerm_pkg::LANE_ONE:  rate_one_reg  <= rate_new;
                    eerm_pkg::LANE_FIVE: rate_five_reg <= rate_new;
                    default:             rate_fifteen_reg <= rate_new;
                endcase
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.lo_capture) begin
            lo_reg <= prod_reg;
        end
        if (cmd.inst_load) begin
            inst_reg <= inst_next;
        end
        if (cmd.diff_load) begin
            neg_reg  <= diff_raw[RB];
            diff_reg <= diff_raw[RB] ? diff_neg[RB-1:0] : diff_raw[RB-1:0];
        end
        if (cmd.step_load) begin
            step_reg <= step_next;
        end
        if (cmd.out_load) begin
            m_data_reg <= {out_fifteen_w[OW-1:0], out_five_w[OW-1:0], out_one_w[OW-1:0]};
        end
    end

    assign status.tick_in    = s_tuser;
    assign status.rates_init = init_reg;
    assign status.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/eerm_checker.sv
// ----------------------------------------------------------------------------
// eerm_checker
// Port-level checks for the rate meter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module eerm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [eerm_pkg::M_DATA_W-1:0] m_tdata
);

    // A result held back by the sink keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    // An item without a tick is answered via S_DONE if the output is empty.
    a_event_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |-> ##2 m_tvalid)
        else $error("event item result late");

endmodule

bind ewma_event_rate_meter_unit eerm_checker u_eerm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb_ewma_event_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// tb_ewma_event_rate_meter_unit
// Self-checking bench for the moving average event rate meter. A driver feeds
// event counts and interval ticks from a backlog with random gaps. A monitor
// accepts the result stream with random stalls and one long hold-off now and
// then, so the block fills and stalls its input. Every accepted item is run
// through a local fixed-point predictor, and each result transaction is
// compared field by field with the oldest predicted rate triple. Phases
// cover default, extreme and random smoothing factors and reciprocals.
// ----------------------------------------------------------------------------
module tb_ewma_event_rate_meter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [eerm_pkg::COUNT_W-1:0] count;
        logic                         tick;
    } event_item_t;

    // Packed so that the one-minute rate lands in the lowest bits of tdata.
    typedef struct packed {
        logic [eerm_pkg::OUT_W-1:0] fifteen;
        logic [eerm_pkg::OUT_W-1:0] five;
        logic [eerm_pkg::OUT_W-1:0] one;
    } rate_triple_t;

    localparam logic [63:0] ACC_LIMIT = (64'd1 << eerm_pkg::ACC_BITS) - 64'd1;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [eerm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [eerm_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [eerm_pkg::COUNT_W-1:0]    s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [eerm_pkg::M_DATA_W-1:0]   m_tdata;

    ewma_event_rate_meter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: register copies and the smoothed rates.
    logic [eerm_pkg::CFG_W-1:0] alpha_one_q;
    logic [eerm_pkg::CFG_W-1:0] alpha_five_q;
    logic [eerm_pkg::CFG_W-1:0] alpha_fifteen_q;
    logic [eerm_pkg::CFG_W-1:0] recip_q;
    logic [63:0]      events_in_interval;
    logic [63:0]      smooth_one;
    logic [63:0]      smooth_five;
    logic [63:0]      smooth_fifteen;
    logic             smoothing_live;

    event_item_t  event_backlog[$];
    rate_triple_t expected_rates[$];
    event_item_t  offered;
    int           send_gap       = 0;
    int           stall_left     = 0;
    int           hold_left      = 0;
    int           results_seen   = 0;
    int           mismatch_count = 0;
    bit           send_idle_on   = 1'b1;
    bit           recv_idle_on   = 1'b1;

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // One smoothing step; a falling rate rounds its step up so that the
    // update is an exact floor toward minus infinity.
    function automatic logic [63:0] blend_rate(logic [63:0] rate,
                                               logic [eerm_pkg::CFG_W-1:0] alpha,
                                               logic [63:0] inst);
        logic [63:0] prod;
        logic [63:0] step;
        if (inst >= rate) begin
            prod = {48'd0, alpha} * (inst - rate);
            step = prod >> 16;
            return (rate + step > eerm_pkg::RATE_MAX_W) ? eerm_pkg::RATE_MAX_W : rate + step;
        end else begin
            prod = {48'd0, alpha} * (rate - inst);
            step = (prod >> 16) + ((prod[15:0] != 16'd0) ? 64'd1 : 64'd0);
            return (step > rate) ? 64'd0 : rate - step;
        end
    endfunction

    function automatic rate_triple_t count_events(event_item_t item);
        logic [63:0]  inst;
        rate_triple_t rates;
        if ({48'd0, item.count} > ACC_LIMIT - events_in_interval)
            events_in_interval = ACC_LIMIT;
        else
            events_in_interval = events_in_interval + {48'd0, item.count};
        if (item.tick) begin
            // Reciprocal and rates share sixteen fraction bits, so no shift.
            inst = events_in_interval * {48'd0, recip_q};
            if (inst > eerm_pkg::RATE_MAX_W)
                inst = eerm_pkg::RATE_MAX_W;
            if (smoothing_live) begin
                smooth_one     = blend_rate(smooth_one, alpha_one_q, inst);
                smooth_five    = blend_rate(smooth_five, alpha_five_q, inst);
                smooth_fifteen = blend_rate(smooth_fifteen, alpha_fifteen_q, inst);
            end else begin
                smooth_one     = inst;
                smooth_five    = inst;
                smooth_fifteen = inst;
                smoothing_live = 1'b1;
            end
            events_in_interval = '0;
        end
        rates.one     = smooth_one[eerm_pkg::OUT_W-1:0];
        rates.five    = smooth_five[eerm_pkg::OUT_W-1:0];
        rates.fifteen = smooth_fifteen[eerm_pkg::OUT_W-1:0];
        return rates;
    endfunction

    function automatic event_item_t random_event(int tick_pct);
        event_item_t item;
        case ($urandom_range(0, 9))
            0: item.count = '0;
            1: item.count = '1;
            2: item.count = eerm_pkg::COUNT_W'($urandom_range(0, 15));
            default: item.count = eerm_pkg::COUNT_W'($urandom);
        endcase
        item.tick = ($urandom_range(0, 99) < tick_pct);
        return item;
    endfunction

    task automatic check_field(input string name, input logic [eerm_pkg::OUT_W-1:0] want,
                               input logic [eerm_pkg::OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: an accepted transaction is predicted at the edge that takes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_rates.push_back(count_events(offered));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (event_backlog.size() > 0) begin
                    offered = event_backlog.pop_front();
                    s_tdata  <= offered.count;
                    s_tuser  <= offered.tick;
                    s_tvalid <= 1'b1;
                    if (send_idle_on)
                        send_gap = idle_length();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results and paces m_tready, including long hold-offs.
    always @(posedge aclk) begin : result_monitor
        rate_triple_t got;
        rate_triple_t want;
        logic         ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (expected_rates.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = expected_rates.pop_front();
                    check_field("rate_one_minute_out", want.one, got.one);
                    check_field("rate_five_minute_out", want.five, got.five);
                    check_field("rate_fifteen_minute_out", want.fifteen, got.fifteen);
                end
                if (results_seen % 500 == 100)
                    hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (recv_idle_on)
                    stall_left = idle_length();
            end
            m_tready <= ready_next;
        end
    end

    task automatic write_reg(input logic [eerm_pkg::CFG_ADDR_W-1:0] index,
                             input logic [eerm_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        case (index)
            eerm_pkg::REG_ALPHA_ONE:     alpha_one_q     = value;
            eerm_pkg::REG_ALPHA_FIVE:    alpha_five_q    = value;
            eerm_pkg::REG_ALPHA_FIFTEEN: alpha_fifteen_q = value;
            eerm_pkg::REG_RECIPROCAL:    recip_q         = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [eerm_pkg::CFG_W-1:0] a_one,
                             input logic [eerm_pkg::CFG_W-1:0] a_five,
                             input logic [eerm_pkg::CFG_W-1:0] a_fifteen,
                             input logic [eerm_pkg::CFG_W-1:0] recip);
        write_reg(eerm_pkg::REG_ALPHA_ONE, a_one);
        write_reg(eerm_pkg::REG_ALPHA_FIVE, a_five);
        write_reg(eerm_pkg::REG_ALPHA_FIFTEEN, a_fifteen);
        write_reg(eerm_pkg::REG_RECIPROCAL, recip);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sampled at the falling edge, after every update of the rising edge has settled.
    task automatic drain();
        do
            @(negedge aclk);
        while (event_backlog.size() != 0 || s_tvalid || expected_rates.size() != 0);
    endtask

    task automatic run_phase(input logic [eerm_pkg::CFG_W-1:0] a_one,
                             input logic [eerm_pkg::CFG_W-1:0] a_five,
                             input logic [eerm_pkg::CFG_W-1:0] a_fifteen,
                             input logic [eerm_pkg::CFG_W-1:0] recip,
                             input int items, input int tick_pct, input bit idling);
        configure(a_one, a_five, a_fifteen, recip);
        send_idle_on = idling;
        recv_idle_on = idling;
        for (int i = 0; i < items; i++)
            event_backlog.push_back(random_event(tick_pct));
        drain();
    endtask

    initial begin
        alpha_one_q        = eerm_pkg::ALPHA_ONE_RST;
        alpha_five_q       = eerm_pkg::ALPHA_FIVE_RST;
        alpha_fifteen_q    = eerm_pkg::ALPHA_FIFTEEN_RST;
        recip_q            = eerm_pkg::RECIPROCAL_RST;
        events_in_interval = '0;
        smooth_one         = '0;
        smooth_five        = '0;
        smooth_fifteen     = '0;
        smoothing_live     = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: register defaults, count extremes, alternating bit
        // patterns, the seeding first tick, then rising and decaying ticks.
        event_backlog.push_back(event_item_t'{count: 16'd0,     tick: 1'b0});
        event_backlog.push_back(event_item_t'{count: 16'hFFFF,  tick: 1'b0});
        event_backlog.push_back(event_item_t'{count: 16'd1,     tick: 1'b0});
        event_backlog.push_back(event_item_t'{count: 16'hAAAA,  tick: 1'b0});
        event_backlog.push_back(event_item_t'{count: 16'h5555,  tick: 1'b1});
        event_backlog.push_back(event_item_t'{count: 16'hFFFF,  tick: 1'b1});
        event_backlog.push_back(event_item_t'{count: 16'd0,     tick: 1'b1});
        event_backlog.push_back(event_item_t'{count: 16'd12345, tick: 1'b1});
        event_backlog.push_back(event_item_t'{count: 16'd0,     tick: 1'b1});
        event_backlog.push_back(event_item_t'{count: 16'hFFFF,  tick: 1'b0});
        event_backlog.push_back(event_item_t'{count: 16'hFFFF,  tick: 1'b1});
        drain();

        // Full, zero and minimal alphas; a zero reciprocal; a one-LSB reciprocal.
        run_phase(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 300, 20, 1'b1);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 150, 30, 1'b1);
        run_phase(16'h8000, 16'($urandom), 16'hFFFF, 16'd1, 300, 10, 1'b0);
        run_phase(eerm_pkg::ALPHA_ONE_RST, eerm_pkg::ALPHA_FIVE_RST,
                  eerm_pkg::ALPHA_FIFTEEN_RST, eerm_pkg::RECIPROCAL_RST,
                  400, 25, 1'b1);
        for (int round = 0; round < 3; round++)
            run_phase(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(1, 65535)),
                      200, (round == 0) ? 2 : 35, 1'b1);

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #250ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/eerm_pkg.sv
rtl/eerm_ctrl.sv
rtl/eerm_dpath.sv
rtl/ewma_event_rate_meter_unit.sv
rtl/eerm_checker.sv
sim/tb_ewma_event_rate_meter_unit.sv
